// ===== hw/rtl/bpid_pkg.sv =====
package bpid_pkg;

  function automatic int max2(int a, int b);
    return (a > b) ? a : b;
  endfunction

  // Design constants.
  localparam int DT_MAX_MS   = 100;
  localparam int ANGLE_WIDTH = 16;
  localparam int MS_PER_S    = 1000;
  localparam int US_PER_S    = 1000000;

  // Field widths.
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 15;
  localparam int ILIM_W  = 23;
  localparam int Q_W     = 12;          // speed_limit width, quotient bits
  localparam int SPD_W   = Q_W + 1;
  localparam int PADDR_W = 5;

  // Datapath widths.
  localparam int DT_W   = $clog2(DT_MAX_MS + 1);
  localparam int K_W    = $clog2(DT_MAX_MS * MS_PER_S + 1);
  localparam int ERR_W  = ANGLE_WIDTH + 1;
  localparam int DE_W   = ANGLE_WIDTH + 2;
  localparam int INT_W  = ILIM_W + 1;
  localparam int CMP_W  = max2(ERR_W, LIM_W);
  localparam int SI_W   = max2(INT_W, ERR_W + DT_W + 1) + 1;
  localparam int MA_W   = GAIN_W + 1 + DE_W;
  localparam int MB_W   = max2(max2(INT_W, $clog2(US_PER_S) + 1), max2(K_W + 1, DE_W));
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int SHIFT_W = 15;          // 32768 of the 32768000 scale
  localparam int N_W    = ACC_W - SHIFT_W;
  localparam int R_W    = K_W + Q_W;
  localparam int CNT_W  = $clog2(Q_W);

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_RESTART = 2'd1,
    OP_STOP    = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_RAN       = 3'd0,
    ST_FELL      = 3'd1,
    ST_SKIPPED   = 3'd2,
    ST_RESTARTED = 3'd3,
    ST_REFUSED   = 3'd4,
    ST_STOPPED   = 3'd5
  } status_t;

  localparam logic [2:0] REG_GAIN_P         = 3'd0;
  localparam logic [2:0] REG_GAIN_I         = 3'd1;
  localparam logic [2:0] REG_GAIN_D         = 3'd2;
  localparam logic [2:0] REG_SPEED_LIMIT    = 3'd3;
  localparam logic [2:0] REG_FALL_LIMIT     = 3'd4;
  localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd5;
  localparam logic [2:0] REG_DEAD_BAND      = 3'd6;
  localparam logic [2:0] REG_UPRIGHT_LIMIT  = 3'd7;

endpackage

// ===== hw/rtl/bpid_in_if.sv =====
interface bpid_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              opcode;
  logic signed [bpid_pkg::ANGLE_WIDTH-1:0] pitch_angle;
  logic [31:0]                             time_ms;

  modport source(output valid, opcode, pitch_angle, time_ms, input ready);
  modport sink(input valid, opcode, pitch_angle, time_ms, output ready);
endinterface

// ===== hw/rtl/bpid_out_if.sv =====
interface bpid_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bpid_pkg::SPD_W-1:0] left_speed;
  logic signed [bpid_pkg::SPD_W-1:0] right_speed;
  logic                              motor_enable;
  logic [2:0]                        status;

  modport source(output valid, left_speed, right_speed, motor_enable, status, input ready);
  modport sink(input valid, left_speed, right_speed, motor_enable, status, output ready);
endinterface

// ===== hw/rtl/balance_pid_with_safety.sv =====
// Channel  Dir  Handshake     Payload
// sample   in   valid/ready   opcode, pitch_angle, time_ms
// result   out  valid/ready   left_speed, right_speed, motor_enable, status
// apb      in   psel/penable  paddr, pwdata, prdata (pready tied high)
//
// A control sample that runs the loop passes through one shared 35x24 signed
// multiplier, used seven times, and then a restoring divider that produces one
// quotient bit per cycle, 12 bits in all. Restart, stop, skipped and fall
// requests go from decode straight to the write-back state. One request is
// worked on at a time; sample.ready is high only when idle, and the state
// returns to idle at the edge that writes the result register. A finished
// result waits in its own register, so a stalled result side delays only the
// write-back of the next result. Reset is synchronous and needs no sweep.
module balance_pid_with_safety (
  input  logic                         clk,
  input  logic                         rst,
  bpid_in_if.sink                      sample,
  bpid_out_if.source                   result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpid_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_DECODE = 15'b000000000000010,
    S_ERRDT  = 15'b000000000000100,
    S_M1     = 15'b000000000001000,
    S_M2     = 15'b000000000010000,
    S_M3     = 15'b000000000100000,
    S_M4     = 15'b000000001000000,
    S_M5     = 15'b000000010000000,
    S_M6     = 15'b000000100000000,
    S_SUM    = 15'b000001000000000,
    S_ABS    = 15'b000010000000000,
    S_CHK    = 15'b000100000000000,
    S_DIV    = 15'b001000000000000,
    S_FIN    = 15'b010000000000000,
    S_WRITE  = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [bpid_pkg::GAIN_W-1:0] gain_p, gain_i, gain_d;
  logic [bpid_pkg::Q_W-1:0]    speed_limit;
  logic [bpid_pkg::LIM_W-1:0]  fall_limit, dead_band, upright_limit;
  logic [bpid_pkg::ILIM_W-1:0] integral_limit;

  // Controller state.
  logic signed [bpid_pkg::INT_W-1:0] integ;
  logic signed [bpid_pkg::ERR_W-1:0] last_error;
  logic [31:0]                       last_time;
  logic                              active;

  // Latched request.
  logic [1:0]                                opcode_r;
  logic signed [bpid_pkg::ANGLE_WIDTH-1:0]   angle_r;
  logic [31:0]                               now_r;

  // Working registers.
  logic signed [bpid_pkg::ERR_W-1:0]  err_r;
  logic signed [bpid_pkg::DE_W-1:0]   de_r;
  logic [bpid_pkg::DT_W-1:0]          dt_r;
  logic [bpid_pkg::K_W-1:0]           k_r;
  logic signed [bpid_pkg::PROD_W-1:0] prod;
  logic signed [bpid_pkg::ACC_W-1:0]  acc;
  logic                               neg_r;
  logic [bpid_pkg::N_W-1:0]           n_r;
  logic                               sat_r;
  logic [bpid_pkg::R_W-1:0]           rem, dsh;
  logic [bpid_pkg::Q_W-1:0]           quo;
  logic [bpid_pkg::CNT_W-1:0]         cnt;
  logic signed [bpid_pkg::SPD_W-1:0]  speed_r;
  bpid_pkg::status_t                  status_r;

  // Result register.
  logic                               out_valid;
  logic signed [bpid_pkg::SPD_W-1:0]  out_left, out_right;
  logic                               out_en;
  logic [2:0]                         out_status;

  // ---------------------------------------------------------------------------
  // Configuration port.
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[bpid_pkg::PADDR_W-1:2];

  always_comb begin
    unique case (cfg_idx)
      bpid_pkg::REG_GAIN_P:         prdata = 32'(gain_p);
      bpid_pkg::REG_GAIN_I:         prdata = 32'(gain_i);
      bpid_pkg::REG_GAIN_D:         prdata = 32'(gain_d);
      bpid_pkg::REG_SPEED_LIMIT:    prdata = 32'(speed_limit);
      bpid_pkg::REG_FALL_LIMIT:     prdata = 32'(fall_limit);
      bpid_pkg::REG_INTEGRAL_LIMIT: prdata = 32'(integral_limit);
      bpid_pkg::REG_DEAD_BAND:      prdata = 32'(dead_band);
      bpid_pkg::REG_UPRIGHT_LIMIT:  prdata = 32'(upright_limit);
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= bpid_pkg::GAIN_W'(1280);
      gain_i         <= '0;
      gain_d         <= '0;
      speed_limit    <= bpid_pkg::Q_W'(200);
      fall_limit     <= bpid_pkg::LIM_W'(5760);
      integral_limit <= bpid_pkg::ILIM_W'(6400000);
      dead_band      <= bpid_pkg::LIM_W'(64);
      upright_limit  <= bpid_pkg::LIM_W'(1280);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bpid_pkg::REG_GAIN_P:         gain_p         <= pwdata[bpid_pkg::GAIN_W-1:0];
        bpid_pkg::REG_GAIN_I:         gain_i         <= pwdata[bpid_pkg::GAIN_W-1:0];
        bpid_pkg::REG_GAIN_D:         gain_d         <= pwdata[bpid_pkg::GAIN_W-1:0];
        bpid_pkg::REG_SPEED_LIMIT:    speed_limit    <= pwdata[bpid_pkg::Q_W-1:0];
        bpid_pkg::REG_FALL_LIMIT:     fall_limit     <= pwdata[bpid_pkg::LIM_W-1:0];
        bpid_pkg::REG_INTEGRAL_LIMIT: integral_limit <= pwdata[bpid_pkg::ILIM_W-1:0];
        bpid_pkg::REG_DEAD_BAND:      dead_band      <= pwdata[bpid_pkg::LIM_W-1:0];
        bpid_pkg::REG_UPRIGHT_LIMIT:  upright_limit  <= pwdata[bpid_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Decode logic.
  logic                              in_acc;
  logic signed [bpid_pkg::ERR_W-1:0] neg_angle, err_c;
  logic [bpid_pkg::ERR_W-1:0]        amag_e;
  logic [bpid_pkg::CMP_W-1:0]        amag;
  logic signed [bpid_pkg::DE_W-1:0]  de_c;
  logic [31:0]                       elapsed;
  logic [bpid_pkg::DT_W-1:0]         dt_c;
  logic                              out_free;

  assign in_acc    = sample.valid & sample.ready;
  assign out_free  = ~out_valid | result.ready;
  assign neg_angle = -bpid_pkg::ERR_W'(angle_r);
  assign amag_e    = angle_r[bpid_pkg::ANGLE_WIDTH-1] ? neg_angle
                                                      : bpid_pkg::ERR_W'(angle_r);
  assign amag      = bpid_pkg::CMP_W'(amag_e);
  assign err_c     = (amag < bpid_pkg::CMP_W'(dead_band)) ? '0 : neg_angle;
  assign de_c      = bpid_pkg::DE_W'(err_c) - bpid_pkg::DE_W'(last_error);
  assign elapsed   = now_r - last_time;

  always_comb begin
    if (elapsed == 32'd0) begin
      dt_c = bpid_pkg::DT_W'(1);
    end else if (elapsed > 32'(bpid_pkg::DT_MAX_MS)) begin
      dt_c = bpid_pkg::DT_W'(bpid_pkg::DT_MAX_MS);
    end else begin
      dt_c = elapsed[bpid_pkg::DT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier.
  logic signed [bpid_pkg::MA_W-1:0]   mul_a;
  logic signed [bpid_pkg::MB_W-1:0]   mul_b;
  logic signed [bpid_pkg::PROD_W-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_ERRDT: begin
        mul_a = bpid_pkg::MA_W'(err_r);
        mul_b = bpid_pkg::MB_W'($signed({1'b0, dt_r}));
      end
      S_M1: begin
        mul_a = bpid_pkg::MA_W'($signed({1'b0, gain_p}));
        mul_b = bpid_pkg::MB_W'(err_r);
      end
      S_M2: begin
        mul_a = bpid_pkg::MA_W'(prod);
        mul_b = bpid_pkg::MB_W'($signed({1'b0, k_r}));
      end
      S_M3: begin
        mul_a = bpid_pkg::MA_W'($signed({1'b0, gain_i}));
        mul_b = bpid_pkg::MB_W'($signed({1'b0, dt_r}));
      end
      S_M4: begin
        mul_a = bpid_pkg::MA_W'(prod);
        mul_b = bpid_pkg::MB_W'(integ);
      end
      S_M5: begin
        mul_a = bpid_pkg::MA_W'($signed({1'b0, gain_d}));
        mul_b = bpid_pkg::MB_W'(de_r);
      end
      S_M6: begin
        mul_a = bpid_pkg::MA_W'(prod);
        mul_b = bpid_pkg::MB_W'(bpid_pkg::US_PER_S);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Integral update with clamp; prod holds err * dt in S_M1.
  logic signed [bpid_pkg::SI_W-1:0] isum, ilim;
  logic signed [bpid_pkg::INT_W-1:0] integ_c;

  assign isum = bpid_pkg::SI_W'(integ) + bpid_pkg::SI_W'(prod);
  assign ilim = bpid_pkg::SI_W'($signed({1'b0, integral_limit}));

  always_comb begin
    priority if (isum > ilim) begin
      integ_c = bpid_pkg::INT_W'(ilim);
    end else if (isum < -ilim) begin
      integ_c = bpid_pkg::INT_W'(-ilim);
    end else begin
      integ_c = bpid_pkg::INT_W'(isum);
    end
  end

  // Divider and final saturation.
  logic [bpid_pkg::ACC_W-1:0] acc_mag;
  logic                       rem_ge;
  logic [bpid_pkg::Q_W-1:0]   qsat;

  assign acc_mag = acc[bpid_pkg::ACC_W-1] ? bpid_pkg::ACC_W'(-acc) : bpid_pkg::ACC_W'(acc);
  assign rem_ge  = rem >= dsh;
  assign qsat    = (sat_r || quo > speed_limit) ? speed_limit : quo;

  // ---------------------------------------------------------------------------
  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_acc) state_next = S_DECODE;
      S_DECODE: begin
        if (opcode_r == bpid_pkg::OP_SAMPLE && active &&
            amag <= bpid_pkg::CMP_W'(fall_limit)) begin
          state_next = S_ERRDT;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_ERRDT:  state_next = S_M1;
      S_M1:     state_next = S_M2;
      S_M2:     state_next = S_M3;
      S_M3:     state_next = S_M4;
      S_M4:     state_next = S_M5;
      S_M5:     state_next = S_M6;
      S_M6:     state_next = S_SUM;
      S_SUM:    state_next = S_ABS;
      S_ABS:    state_next = S_CHK;
      S_CHK:    state_next = S_DIV;
      S_DIV:    if (cnt == '0) state_next = S_FIN;
      S_FIN:    state_next = S_WRITE;
      S_WRITE:  if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign sample.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      active     <= 1'b0;
      integ      <= '0;
      last_error <= '0;
      last_time  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_WRITE && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            opcode_r <= sample.opcode;
            angle_r  <= sample.pitch_angle;
            now_r    <= sample.time_ms;
          end
        end
        S_DECODE: begin
          speed_r <= '0;
          unique case (opcode_r)
            bpid_pkg::OP_SAMPLE: begin
              if (amag > bpid_pkg::CMP_W'(fall_limit)) begin
                status_r <= active ? bpid_pkg::ST_FELL : bpid_pkg::ST_SKIPPED;
                active   <= 1'b0;
              end else if (!active) begin
                status_r <= bpid_pkg::ST_SKIPPED;
              end else begin
                status_r   <= bpid_pkg::ST_RAN;
                err_r      <= err_c;
                de_r       <= de_c;
                dt_r       <= dt_c;
                last_error <= err_c;
                last_time  <= now_r;
              end
            end
            bpid_pkg::OP_RESTART: begin
              if (amag < bpid_pkg::CMP_W'(upright_limit)) begin
                integ      <= '0;
                last_error <= '0;
                last_time  <= now_r;
                active     <= 1'b1;
                status_r   <= bpid_pkg::ST_RESTARTED;
              end else begin
                status_r <= bpid_pkg::ST_REFUSED;
              end
            end
            bpid_pkg::OP_STOP: begin
              active   <= 1'b0;
              status_r <= bpid_pkg::ST_STOPPED;
            end
            default: status_r <= bpid_pkg::ST_SKIPPED;
          endcase
        end
        S_ERRDT: begin
          prod <= mul_p;
          k_r  <= bpid_pkg::K_W'(dt_r) * bpid_pkg::K_W'(bpid_pkg::MS_PER_S);
        end
        S_M1: begin
          prod  <= mul_p;
          integ <= integ_c;
        end
        S_M2: prod <= mul_p;
        S_M3: begin
          prod <= mul_p;
          acc  <= bpid_pkg::ACC_W'(prod);
        end
        S_M4: prod <= mul_p;
        S_M5: begin
          prod <= mul_p;
          acc  <= acc + bpid_pkg::ACC_W'(prod);
        end
        S_M6: prod <= mul_p;
        S_SUM: acc <= acc + bpid_pkg::ACC_W'(prod);
        S_ABS: begin
          // Dropping the low 15 bits first leaves the truncated quotient unchanged.
          neg_r <= acc[bpid_pkg::ACC_W-1];
          n_r   <= acc_mag[bpid_pkg::ACC_W-1:bpid_pkg::SHIFT_W];
        end
        S_CHK: begin
          sat_r <= n_r >= (bpid_pkg::N_W'(k_r) << bpid_pkg::Q_W);
          rem   <= bpid_pkg::R_W'(n_r);
          dsh   <= bpid_pkg::R_W'(k_r) << (bpid_pkg::Q_W - 1);
          cnt   <= bpid_pkg::CNT_W'(bpid_pkg::Q_W - 1);
        end
        S_DIV: begin
          if (rem_ge) rem <= rem - dsh;
          quo <= {quo[bpid_pkg::Q_W-2:0], rem_ge};
          dsh <= dsh >> 1;
          cnt <= cnt - 1'b1;
        end
        S_FIN: begin
          speed_r <= neg_r ? -bpid_pkg::SPD_W'(qsat) : bpid_pkg::SPD_W'(qsat);
        end
        S_WRITE: begin
          if (out_free) begin
            out_left   <= speed_r;
            out_right  <= -speed_r;
            out_en     <= active;
            out_status <= status_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign result.valid        = out_valid;
  assign result.left_speed   = out_left;
  assign result.right_speed  = out_right;
  assign result.motor_enable = out_en;
  assign result.status       = out_status;

  // ---------------------------------------------------------------------------
  // Assertions.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !sample.ready)
    else $error("sample accepted while a request was still in work");

  a_right_mirrors_left: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.right_speed == -result.left_speed)
    else $error("right speed is not the negated left speed");

  a_zero_unless_ran: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != bpid_pkg::ST_RAN |-> result.left_speed == '0)
    else $error("nonzero speed on a result that did not run the loop");

  a_off_after_stop: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == bpid_pkg::ST_FELL ||
                     result.status == bpid_pkg::ST_STOPPED) |-> !result.motor_enable)
    else $error("motors enabled after a fall or a stop");

endmodule

// ===== dv/balance_pid_with_safety_checker.sv =====
`timescale 1ns / 1ps
module balance_pid_with_safety_checker (
  input  logic                         clk,
  input  logic                         rst,
  bpid_in_if                           sample,
  bpid_out_if                          result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpid_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic [31:0]                  prdata,
  input  logic                         pready,
  output int                           errors,
  output int                           pending,
  output int                           checked
);
  import bpid_pkg::*;

  typedef struct packed {
    logic signed [SPD_W-1:0] left;
    logic signed [SPD_W-1:0] right;
    logic                    enable;
    status_t                 st;
  } motor_cmd_t;

  // Register copies, kept as plain integers for the loop arithmetic.
  longint kp, ki, kd, spd_lim, fall_lim, ilim, dead, upright;

  // Loop state.
  longint      integ;
  longint      last_err;
  logic [31:0] last_t;
  bit          armed;

  motor_cmd_t cmd_q[$];
  int         fault_cnt;
  int         done_cnt;

  function automatic logic [31:0] reg_readback(logic [2:0] idx);
    case (idx)
      REG_GAIN_P:         return kp[31:0];
      REG_GAIN_I:         return ki[31:0];
      REG_GAIN_D:         return kd[31:0];
      REG_SPEED_LIMIT:    return spd_lim[31:0];
      REG_FALL_LIMIT:     return fall_lim[31:0];
      REG_INTEGRAL_LIMIT: return ilim[31:0];
      REG_DEAD_BAND:      return dead[31:0];
      default:            return upright[31:0];
    endcase
  endfunction

  function automatic motor_cmd_t predict_cmd(logic [1:0] op,
                                             logic signed [ANGLE_WIDTH-1:0] pitch,
                                             logic [31:0] now);
    motor_cmd_t  cmd;
    longint      ang, tilt, err, de, num, spd, dt, neg;
    logic [31:0] elapsed;
    status_t     st;
    ang  = pitch;
    tilt = (ang < 0) ? -ang : ang;
    spd  = 0;
    st   = ST_SKIPPED;
    case (op)
      OP_SAMPLE: begin
        if (tilt > fall_lim) begin
          if (armed) begin
            armed = 1'b0;
            st    = ST_FELL;
          end
        end else if (armed) begin
          elapsed = now - last_t;
          if (elapsed == 0) dt = 1;
          else if (elapsed > DT_MAX_MS) dt = DT_MAX_MS;
          else dt = elapsed;
          err = -ang;
          if (((err < 0) ? -err : err) < dead) err = 0;
          integ = integ + err * dt;
          if (integ > ilim) integ = ilim;
          if (integ < -ilim) integ = -ilim;
          de  = err - last_err;
          num = kp * err * 1000 * dt + ki * integ * dt + kd * de * 1000000;
          // Integer division truncates toward zero, as the block does.
          spd = num / (32768000 * dt);
          if (spd > spd_lim) spd = spd_lim;
          if (spd < -spd_lim) spd = -spd_lim;
          last_err = err;
          last_t   = now;
          st       = ST_RAN;
        end
      end
      OP_RESTART: begin
        if (tilt < upright) begin
          integ    = 0;
          last_err = 0;
          last_t   = now;
          armed    = 1'b1;
          st       = ST_RESTARTED;
        end else begin
          st = ST_REFUSED;
        end
      end
      OP_STOP: begin
        armed = 1'b0;
        st    = ST_STOPPED;
      end
      default: st = ST_SKIPPED;
    endcase
    neg        = -spd;
    cmd.left   = spd[SPD_W-1:0];
    cmd.right  = neg[SPD_W-1:0];
    cmd.enable = armed;
    cmd.st     = st;
    return cmd;
  endfunction

  task automatic note_fault(input string msg);
    fault_cnt++;
    if (fault_cnt <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    motor_cmd_t  want;
    logic [31:0] reg_val;
    if (rst) begin
      kp        = 1280;
      ki        = 0;
      kd        = 0;
      spd_lim   = 200;
      fall_lim  = 5760;
      ilim      = 6400000;
      dead      = 64;
      upright   = 1280;
      integ     = 0;
      last_err  = 0;
      last_t    = '0;
      armed     = 1'b0;
      cmd_q.delete();
      fault_cnt = 0;
      done_cnt  = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[PADDR_W-1:2])
            REG_GAIN_P:         kp       = pwdata[GAIN_W-1:0];
            REG_GAIN_I:         ki       = pwdata[GAIN_W-1:0];
            REG_GAIN_D:         kd       = pwdata[GAIN_W-1:0];
            REG_SPEED_LIMIT:    spd_lim  = pwdata[Q_W-1:0];
            REG_FALL_LIMIT:     fall_lim = pwdata[LIM_W-1:0];
            REG_INTEGRAL_LIMIT: ilim     = pwdata[ILIM_W-1:0];
            REG_DEAD_BAND:      dead     = pwdata[LIM_W-1:0];
            default:            upright  = pwdata[LIM_W-1:0];
          endcase
        end else begin
          reg_val = reg_readback(paddr[PADDR_W-1:2]);
          if (prdata !== reg_val)
            note_fault($sformatf("register read at 0x%0h: expected 0x%0h, got 0x%0h",
                                 paddr, reg_val, prdata));
        end
      end
      if (result.valid && result.ready) begin
        if (cmd_q.size() == 0) begin
          note_fault($sformatf("unexpected result: left %0d right %0d enable %0b status %0d",
                               result.left_speed, result.right_speed,
                               result.motor_enable, result.status));
        end else begin
          want = cmd_q.pop_front();
          done_cnt++;
          if (result.left_speed !== want.left || result.right_speed !== want.right ||
              result.motor_enable !== want.enable || result.status !== want.st)
            note_fault($sformatf({"result %0d mismatch: expected left %0d right %0d ",
                                  "enable %0b status %0d, got left %0d right %0d ",
                                  "enable %0b status %0d"},
                                 done_cnt, want.left, want.right, want.enable, want.st,
                                 result.left_speed, result.right_speed,
                                 result.motor_enable, result.status));
        end
      end
      if (sample.valid && sample.ready)
        cmd_q.push_back(predict_cmd(sample.opcode, sample.pitch_angle, sample.time_ms));
    end
    errors  <= fault_cnt;
    pending <= cmd_q.size();
    checked <= done_cnt;
  end

endmodule

// ===== dv/balance_pid_with_safety_tb.sv =====
`timescale 1ns / 1ps
module balance_pid_with_safety_tb;
  import bpid_pkg::*;

  // The block ignores this opcode and answers it as a skipped request.
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int PHASES           = 6;
  localparam int REQS_PER_PHASE   = 100;
  localparam int STALL_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 60;

  typedef struct {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [Q_W-1:0]    spd;
    logic [LIM_W-1:0]  fall;
    logic [ILIM_W-1:0] ilim;
    logic [LIM_W-1:0]  dead;
    logic [LIM_W-1:0]  upright;
  } tuning_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int          errors;
  int          pending;
  int          checked;
  int          sent = 0;
  int          stall_cycles = 0;
  bit          steady = 1'b0;
  logic [31:0] clock_ms;

  bpid_in_if  sample_ch ();
  bpid_out_if result_ch ();

  balance_pid_with_safety u_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  balance_pid_with_safety_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .errors  (errors),
    .pending (pending),
    .checked (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    result_ch.ready <= steady || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
      $display("balance_pid_with_safety_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // A transfer leaves psel high so that another one can follow at once;
  // apb_release ends a batch.
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apb_read(input logic [2:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_all();
    apb_read(REG_GAIN_P);
    apb_read(REG_GAIN_I);
    apb_read(REG_GAIN_D);
    apb_read(REG_SPEED_LIMIT);
    apb_read(REG_FALL_LIMIT);
    apb_read(REG_INTEGRAL_LIMIT);
    apb_read(REG_DEAD_BAND);
    apb_read(REG_UPRIGHT_LIMIT);
  endtask

  // Unused upper bits of each write carry junk that the block must drop.
  task automatic apply_tuning(input tuning_t tn);
    apb_write(REG_GAIN_P, {16'($urandom), tn.kp});
    apb_write(REG_GAIN_I, {16'($urandom), tn.ki});
    apb_write(REG_GAIN_D, {16'($urandom), tn.kd});
    apb_write(REG_SPEED_LIMIT, {20'($urandom), tn.spd});
    apb_write(REG_FALL_LIMIT, {17'($urandom), tn.fall});
    apb_write(REG_INTEGRAL_LIMIT, {9'($urandom), tn.ilim});
    apb_write(REG_DEAD_BAND, {17'($urandom), tn.dead});
    apb_write(REG_UPRIGHT_LIMIT, {17'($urandom), tn.upright});
    read_all();
    apb_release();
  endtask

  function automatic tuning_t phase_tuning(int p);
    tuning_t tn;
    tn.kp      = GAIN_W'($urandom_range(4000));
    tn.ki      = GAIN_W'($urandom_range(2000));
    tn.kd      = GAIN_W'($urandom_range(2000));
    tn.spd     = Q_W'($urandom_range(4095, 50));
    tn.fall    = LIM_W'($urandom_range(8000, 3000));
    tn.ilim    = ILIM_W'($urandom_range(500000));
    tn.dead    = LIM_W'($urandom_range(200));
    tn.upright = LIM_W'($urandom_range(2000, 500));
    case (p)
      1: begin
        tn.kp = '1; tn.ki = '1; tn.kd = '1; tn.spd = '1;
        tn.fall = '1; tn.ilim = '1; tn.dead = '1; tn.upright = '1;
      end
      2: begin
        tn.kp = '0; tn.ki = '0; tn.kd = '0; tn.spd = '0;
        tn.fall = '0; tn.ilim = '0; tn.dead = '0; tn.upright = '0;
      end
      3: begin
        tn.kp = '1; tn.ki = '1; tn.kd = '1; tn.spd = Q_W'($urandom);
        tn.fall = '1; tn.ilim = '1; tn.dead = '0; tn.upright = '1;
      end
      4: begin
        tn.kp = GAIN_W'($urandom); tn.ki = GAIN_W'($urandom); tn.kd = GAIN_W'($urandom);
        tn.spd = Q_W'($urandom); tn.fall = LIM_W'($urandom); tn.ilim = ILIM_W'($urandom);
        tn.dead = LIM_W'($urandom); tn.upright = LIM_W'($urandom);
      end
      default: ;
    endcase
    return tn;
  endfunction

  task automatic send(input logic [1:0] op, input logic signed [ANGLE_WIDTH-1:0] pitch,
                      input logic [31:0] stamp);
    while (!steady && $urandom_range(99) < 16) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.opcode      <= op;
    sample_ch.pitch_angle <= pitch;
    sample_ch.time_ms     <= stamp;
    do @(posedge clk); while (!sample_ch.ready);
    sent++;
  endtask

  // Mostly restart-then-run sequences near upright, with stops, the unused
  // opcode, tilts at the thresholds and full-range noise mixed in.
  task automatic random_request(input tuning_t tn);
    int r, a, edge_mag;
    logic [1:0] op;
    logic signed [ANGLE_WIDTH-1:0] pitch;
    r = $urandom_range(99);
    if (r < 12) op = OP_RESTART;
    else if (r < 16) op = OP_STOP;
    else if (r < 19) op = OP_SPARE;
    else op = OP_SAMPLE;
    a = $urandom_range(99);
    if (a < 65) begin
      edge_mag = $urandom_range(1500);
    end else if (a < 88) begin
      case ($urandom_range(2))
        0: edge_mag = tn.fall;
        1: edge_mag = tn.upright;
        default: edge_mag = tn.dead;
      endcase
      edge_mag = edge_mag + $urandom_range(2) - 1;
    end else begin
      edge_mag = $urandom_range(32768);
    end
    pitch = ANGLE_WIDTH'($urandom_range(1) ? -edge_mag : edge_mag);
    r = $urandom_range(99);
    if (r < 3) clock_ms = $urandom;
    else if (r >= 8) clock_ms = clock_ms + $urandom_range(130, 1);
    send(op, pitch, clock_ms);
  endtask

  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    tuning_t tn;
    rst                   <= 1'b1;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    sample_ch.valid       <= 1'b0;
    sample_ch.opcode      <= OP_SAMPLE;
    sample_ch.pitch_angle <= '0;
    sample_ch.time_ms     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_all();
    apb_release();

    // Directed requests under the reset tuning.
    send(OP_SAMPLE, 0, 10);
    send(OP_RESTART, 1280, 20);
    send(OP_RESTART, -1279, 1000);
    send(OP_SAMPLE, 0, 1000);
    send(OP_SAMPLE, 63, 1005);
    send(OP_SAMPLE, -64, 1010);
    send(OP_SAMPLE, 5760, 1050);
    send(OP_SAMPLE, -5760, 1300);
    send(OP_SAMPLE, -5761, 1310);
    send(OP_SAMPLE, 100, 1320);
    send(OP_RESTART, 0, 32'hFFFF_FFF0);
    send(OP_SAMPLE, 300, 32'h0000_0010);
    send(OP_SAMPLE, -200, 32'hFFFF_FFFF);
    send(OP_SPARE, 0, 0);
    send(OP_STOP, 0, 5);
    send(OP_SAMPLE, 0, 6);
    send(OP_RESTART, 32767, 7);
    send(OP_RESTART, 0, 8);
    send(OP_SAMPLE, -32768, 9);
    send(OP_STOP, 32767, 10);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      tn = phase_tuning(p);
      apply_tuning(tn);
      steady   = (p == PHASES - 1);
      clock_ms = (p == 4) ? 32'hFFFF_FFFF - $urandom_range(3000) : $urandom;
      for (int n = 0; n < REQS_PER_PHASE; n++) random_request(tn);
      wait_idle();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d results checked over %0d register settings",
             sent, checked, PHASES + 1);
    $display("settings included reset values, all-zero and all-max registers");
    if (errors == 0) begin
      $display("balance_pid_with_safety_tb OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("balance_pid_with_safety_tb NOT OK");
    end
    $finish;
  end

endmodule
